[src/wwpf_pkg.sv]
package wwpf_pkg;

    // Pixel and configuration widths fixed by the interface
    localparam int PIX_W = 8;
    localparam int HUE_W = 4;

    // Opcodes on the request channel
    localparam logic OP_PRELOAD = 1'b0;
    localparam logic OP_FILTER  = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [HUE_W-1:0] hue_t;

endpackage

[src/wwpf_addr_gen.sv]
module wwpf_addr_gen #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 185,
    parameter int DEPTH        = FRAME_WIDTH + 3,
    parameter int ADDR_W       = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              opcode,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              rd_hit
);

    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int POS_MIN_W = $clog2(PIX_COUNT);
    // bits 12:10 of the position select the waver, so keep at least 13 bits
    localparam int POS_W     = (POS_MIN_W > 13) ? POS_MIN_W : 13;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PIX_COUNT - 1);
    localparam logic [2:0] WAVER_CENTER = 3'd4;

    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    logic [2:0]       waver;
    logic [2:0]       mag;
    logic [CNT_W-1:0] back_dist;
    logic [CNT_W-1:0] ptr_ext;
    logic [CNT_W-1:0] diff;

    // Look-back distance: one row minus one, plus |waver - 4|
    always_comb begin
        waver     = pos_reg[12:10];
        mag       = (waver >= WAVER_CENTER) ? (waver - WAVER_CENTER) : (WAVER_CENTER - waver);
        back_dist = CNT_W'(FRAME_WIDTH - 1) + CNT_W'(mag);
        ptr_ext   = CNT_W'(wr_ptr_reg);
        if (ptr_ext >= back_dist) begin
            diff = ptr_ext - back_dist;
        end else begin
            diff = ptr_ext + (CNT_W'(DEPTH) - back_dist);
        end
    end

    assign rd_addr = diff[ADDR_W-1:0];
    // Entries beyond the fill count were never pushed and read as zero
    assign rd_hit  = (back_dist <= fill_reg);
    assign wr_addr = wr_ptr_reg;

    // Ring pointer and fill count advance per accepted request; the frame position counts down on filter requests only
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        if (accept) begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (fill_reg != CNT_W'(DEPTH)) begin
                fill_next = fill_reg + 1'b1;
            end
            if (opcode == wwpf_pkg::OP_FILTER) begin
                pos_next = (pos_reg == '0) ? LAST_POS : pos_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            pos_reg    <= LAST_POS;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

[src/wwpf_hist_ram.sv]
module wwpf_hist_ram #(
    parameter int DEPTH  = 323,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  wwpf_pkg::pixel_t   wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output wwpf_pkg::pixel_t   rdata
);

    wwpf_pkg::pixel_t mem [DEPTH];
    wwpf_pkg::pixel_t rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/wwpf_blend.sv]
module wwpf_blend (
    input  wwpf_pkg::pixel_t pixel_in,
    input  wwpf_pkg::pixel_t hist_pixel,
    input  logic             hist_hit,
    input  wwpf_pkg::hue_t   hue,
    output wwpf_pkg::pixel_t pixel_out
);

    logic [3:0] hist_nib;
    logic [4:0] sum;

    // Average of the two low nibbles, hue in the high nibble; pixels with bits 5:4 clear pass through
    always_comb begin
        hist_nib = hist_hit ? hist_pixel[3:0] : 4'h0;
        sum      = {1'b0, pixel_in[3:0]} + {1'b0, hist_nib};
        if (pixel_in[5:4] == 2'b00) begin
            pixel_out = pixel_in;
        end else begin
            pixel_out = {hue, sum[4:1]};
        end
    end

endmodule

[src/water_wave_pixel_filter_top.sv]
// Stages: an accepted request loads the input register; a filter result then loads the
// output register once that register is empty or its result is being taken.
// Throughput: one request per cycle while results are taken; history memory does one write
// and one registered read per cycle; the shortest look-back distance exceeds the pipeline.
// Reset (aresetn, synchronous, active low) clears the pipeline, counters and hue; history
// entries not yet pushed read as zero through a fill count, so no clearing pass is run.
module water_wave_pixel_filter_top #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 185
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic [7:0]             s_source_pixel,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_pixel_out,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [3:0]             cfg_data
);

    localparam int DEPTH  = FRAME_WIDTH + 3;
    localparam int ADDR_W = $clog2(DEPTH);

    logic               accept;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_hit;
    wwpf_pkg::pixel_t   hist_pixel;
    wwpf_pkg::pixel_t   blend_pixel;
    wwpf_pkg::pixel_t   push_pixel;

    wwpf_pkg::hue_t     hue_reg;
    logic               a_vld_reg, a_vld_next;
    logic               a_op_reg;
    wwpf_pkg::pixel_t   a_px_reg;
    logic [ADDR_W-1:0]  a_waddr_reg;
    logic               a_hit_reg;
    logic               m_valid_reg, m_valid_next;
    wwpf_pkg::pixel_t   m_pixel_reg;

    logic               a_need_out;
    logic               a_adv;

    // Hue register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_reg <= '0;
        end else if (cfg_valid) begin
            hue_reg <= cfg_data;
        end
    end

    // Handshake: stage A moves on when the output slot is free or it makes no result
    assign a_need_out = a_vld_reg && (a_op_reg == wwpf_pkg::OP_FILTER);
    assign a_adv      = a_vld_reg && (!a_need_out || !m_valid_reg || m_ready);
    assign s_ready    = !a_vld_reg || a_adv;
    assign accept     = s_valid && s_ready;

    wwpf_addr_gen #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .DEPTH        (DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_addr_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .opcode  (s_opcode),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_hit  (rd_hit)
    );

    wwpf_hist_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (a_adv),
        .waddr (a_waddr_reg),
        .wdata (push_pixel),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (hist_pixel)
    );

    wwpf_blend u_blend (
        .pixel_in   (a_px_reg),
        .hist_pixel (hist_pixel),
        .hist_hit   (a_hit_reg),
        .hue        (hue_reg),
        .pixel_out  (blend_pixel)
    );

    // Preloads push the raw pixel, filters push their result
    assign push_pixel = (a_op_reg == wwpf_pkg::OP_PRELOAD) ? a_px_reg : blend_pixel;

    // Stage A: input register
    always_comb begin
        a_vld_next = a_vld_reg;
        if (accept) begin
            a_vld_next = 1'b1;
        end else if (a_adv) begin
            a_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_op_reg    <= s_opcode;
            a_px_reg    <= s_source_pixel;
            a_waddr_reg <= wr_addr;
            a_hit_reg   <= rd_hit;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (a_adv && a_need_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv && a_need_out) begin
            m_pixel_reg <= blend_pixel;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_reg;

endmodule

[src/wwpf_checker.sv]
module wwpf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_opcode,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_pixel_out,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [3:0] cfg_data
);

    logic [3:0] hue_reg;
    logic [2:0] pend_reg, pend_next;
    logic       req_in;
    logic       res_out;

    // Track the hue and the filter requests still owed a result
    assign req_in  = s_valid && s_ready && (s_opcode == wwpf_pkg::OP_FILTER);
    assign res_out = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (req_in && !res_out) begin
            pend_next = pend_reg + 1'b1;
        end else if (!req_in && res_out) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_reg  <= '0;
            pend_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                hue_reg <= cfg_data;
            end
            pend_reg <= pend_next;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out))
        else $error("stalled result changed");

    // No result without an outstanding filter request
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 3'd0)
        else $error("result without filter request");

    // The pipeline holds at most two filter requests
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 3'd2)
        else $error("too many filter requests in flight");

    // A result is either a passed-through pixel or carries the hue nibble
    a_result_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_out[5:4] == 2'b00) || (m_pixel_out[7:4] == hue_reg))
        else $error("result neither passed through nor blended");

    // The block is ready for a request right after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("not ready after reset");

endmodule

bind water_wave_pixel_filter_top wwpf_checker u_wwpf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_opcode    (s_opcode),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_pixel_out (m_pixel_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
);

[verif/tb.sv]
`timescale 1ns / 1ps

// Tracks the ripple filter: its own copy of the output history, frame index and hue,
// plus the queue of pixels still owed on the result channel.
class ripple_scoreboard #(int WIDTH = 320, int HEIGHT = 185);
    localparam int DEPTH = WIDTH + 3;
    localparam int LAST  = WIDTH * HEIGHT - 1;

    wwpf_pkg::pixel_t history [DEPTH];
    int unsigned      wr_ptr;
    int unsigned      position;
    wwpf_pkg::hue_t   hue;
    wwpf_pkg::pixel_t expected_pixels [$];
    int unsigned      failures;
    int unsigned      requests;
    int unsigned      preloads;
    int unsigned      blended;
    int unsigned      results;
    int unsigned      wraps;

    function new();
        foreach (history[i]) history[i] = '0;
        wr_ptr   = 0;
        position = LAST;
        hue      = '0;
        failures = 0;
        requests = 0;
        preloads = 0;
        blended  = 0;
        results  = 0;
        wraps    = 0;
    endfunction

    function void push_history(wwpf_pkg::pixel_t px);
        history[wr_ptr] = px;
        wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
    endfunction

    // Accepted request: preloads only feed the history, filter pixels owe one result
    function void note_request(logic op, wwpf_pkg::pixel_t px);
        wwpf_pkg::pixel_t res;
        wwpf_pkg::pixel_t below;
        int unsigned      waver;
        int unsigned      reach;
        logic [4:0]       sum;
        requests++;
        if (op == wwpf_pkg::OP_PRELOAD) begin
            preloads++;
            push_history(px);
            return;
        end
        if (px[5:4] == 2'b00) begin
            res = px;
        end else begin
            // row below, shifted by |waver - 4| where waver is index bits 12:10
            waver = (position >> 10) & 32'd7;
            reach = WIDTH - 1 + ((waver >= 4) ? waver - 4 : 4 - waver);
            below = history[(wr_ptr + DEPTH - reach) % DEPTH];
            sum   = {1'b0, px[3:0]} + {1'b0, below[3:0]};
            res   = {hue, sum[4:1]};
            blended++;
        end
        push_history(res);
        expected_pixels.push_back(res);
        if (position == 0) begin
            position = LAST;
            wraps++;
        end else begin
            position--;
        end
    endfunction

    // Accepted result: compare with the oldest pixel owed
    function void check_pixel(wwpf_pkg::pixel_t got);
        wwpf_pkg::pixel_t want;
        results++;
        if (expected_pixels.size() == 0) begin
            $error("pixel_out: unexpected result, expected none, actual %02h", got);
            failures++;
            return;
        end
        want = expected_pixels.pop_front();
        if (got !== want) begin
            $error("pixel_out mismatch: expected %02h, actual %02h", want, got);
            failures++;
        end
    endfunction
endclass

module tb;
    localparam int WIDTH       = 320;
    localparam int HEIGHT      = 185;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SWEEP_ITEMS = 50;

    logic             aclk;
    logic             aresetn        = 1'b0;
    logic             s_valid        = 1'b0;
    logic             s_ready;
    logic             s_opcode       = wwpf_pkg::OP_PRELOAD;
    wwpf_pkg::pixel_t s_source_pixel = '0;
    logic             m_valid;
    logic             m_ready        = 1'b0;
    wwpf_pkg::pixel_t m_pixel_out;
    logic             cfg_valid      = 1'b0;
    logic             cfg_ready;
    wwpf_pkg::hue_t   cfg_data       = '0;

    ripple_scoreboard #(WIDTH, HEIGHT) sb;

    bit          tx_quiet     = 1'b0;
    bit          rx_quiet     = 1'b0;
    int unsigned rx_hold      = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hue_writes   = 0;

    water_wave_pixel_filter_top #(
        .FRAME_WIDTH  (WIDTH),
        .FRAME_HEIGHT (HEIGHT)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_source_pixel (s_source_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result checking and the count of cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) sb.check_pixel(m_pixel_out);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        int unsigned gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold != 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // One request; valid drops only when a gap precedes it
    task automatic send_request(input logic op, input wwpf_pkg::pixel_t px);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_source_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, px);
    endtask

    task automatic send_mixed(input int unsigned count, input int unsigned preload_pct);
        repeat (count)
            send_request(($urandom_range(0, 99) < preload_pct) ?
                             wwpf_pkg::OP_PRELOAD : wwpf_pkg::OP_FILTER,
                         wwpf_pkg::pixel_t'($urandom));
    endtask

    task automatic write_hue(input wwpf_pkg::hue_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.hue = value;
        hue_writes++;
    endtask

    // Wait until every owed pixel has come out, then let the pipeline empty
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int unsigned sweep;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Hue at reset value, empty history: blends read zeros
        send_request(wwpf_pkg::OP_FILTER, 8'h00);
        send_request(wwpf_pkg::OP_FILTER, 8'hCF);
        send_request(wwpf_pkg::OP_FILTER, 8'hFF);
        send_request(wwpf_pkg::OP_FILTER, 8'h10);
        send_request(wwpf_pkg::OP_FILTER, 8'h20);
        send_request(wwpf_pkg::OP_FILTER, 8'h30);
        send_request(wwpf_pkg::OP_FILTER, 8'h3F);
        send_request(wwpf_pkg::OP_PRELOAD, 8'hFF);
        send_request(wwpf_pkg::OP_PRELOAD, 8'h00);
        send_request(wwpf_pkg::OP_FILTER, 8'h8F);
        drain_results();

        // Full hue, a few more corners
        write_hue(4'hF);
        send_request(wwpf_pkg::OP_FILTER, 8'h1F);
        send_request(wwpf_pkg::OP_FILTER, 8'hEF);
        send_request(wwpf_pkg::OP_FILTER, 8'h20);
        send_request(wwpf_pkg::OP_PRELOAD, 8'hA5);
        send_request(wwpf_pkg::OP_FILTER, 8'h40);

        // Row-below preload burst, then mostly filter pixels
        repeat (40) send_request(wwpf_pkg::OP_PRELOAD, wwpf_pkg::pixel_t'($urandom));
        send_mixed(80, 5);
        drain_results();

        // Zero hue; sender at full rate while the receiver holds off
        write_hue(4'h0);
        tx_quiet = 1'b1;
        rx_hold  = HOLD_CYCLES;
        send_mixed(100, 10);
        drain_results();
        tx_quiet = 1'b0;

        // Mid hue, heavy preload noise
        write_hue(wwpf_pkg::hue_t'($urandom_range(1, 14)));
        send_mixed(100, 30);
        drain_results();

        // Both sides at full rate, no idling anywhere
        write_hue(wwpf_pkg::hue_t'($urandom));
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        sweep = SWEEP_ITEMS;
        while (sweep != 0) begin
            if ($urandom_range(0, 99) == 0) begin
                send_request(wwpf_pkg::OP_PRELOAD, wwpf_pkg::pixel_t'($urandom));
            end else begin
                send_request(wwpf_pkg::OP_FILTER, wwpf_pkg::pixel_t'($urandom));
                sweep--;
            end
        end
        drain_results();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // Idling back on
        write_hue(wwpf_pkg::hue_t'($urandom));
        send_mixed(60, 15);
        drain_results();

        $display("Covered %0d requests (%0d history preloads), %0d results, %0d blended",
                 sb.requests, sb.preloads, sb.results, sb.blended);
        $display("Hue loaded %0d times incl. 0 and 15; frame index wrapped %0d time(s)",
                 hue_writes, sb.wraps);
        if (sb.failures == 0 && sb.expected_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
